// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros sample on the rising edge of clk and stay quiet during reset.
`define CHK_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aes256 port check failed");

`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aes256 port check failed");

`endif

// ----- src/aes256_pkg.sv -----
package aes256_pkg;

  localparam int ROUNDS    = 14;
  localparam int KEY_WORDS = 8;
  localparam int RK_WORDS  = 4 * (ROUNDS + 1);
  localparam int KEY_REGS  = 4;
  localparam int CFG_IDX_W = $clog2(KEY_REGS);
  localparam int RK_IDX_W  = $clog2(RK_WORDS);

  typedef logic [0:15][7:0]  state_t;
  typedef logic [127:0]      rkey_t;
  typedef logic [255:0][7:0] box_t;

  typedef struct packed {
    logic        action;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_word_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_word_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        p = p ^ x;
      end
      x = xtime(x);
    end
    return p;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
    return 8'((v << n) | (v >> (8 - n)));
  endfunction

  function automatic box_t gen_box(input logic inverse);
    box_t       box;
    logic [7:0] x8;
    logic [7:0] acc;
    logic [7:0] base;
    logic [7:0] s;
    logic [7:0] e;
    box = '0;
    for (int x = 0; x < 256; x++) begin
      x8   = 8'(x);
      acc  = 8'h01;
      base = x8;
      e    = 8'd254;
      for (int k = 0; k < 8; k++) begin
        if (e[k]) begin
          acc = gmul(acc, base);
        end
        base = gmul(base, base);
      end
      if (x8 == 8'h00) begin
        acc = 8'h00;
      end
      s = acc ^ rotl8(acc, 1) ^ rotl8(acc, 2) ^ rotl8(acc, 3) ^ rotl8(acc, 4) ^ 8'h63;
      if (inverse) begin
        box[s] = x8;
      end else begin
        box[x8] = s;
      end
    end
    return box;
  endfunction

  localparam box_t FWD_BOX = gen_box(1'b0);
  localparam box_t INV_BOX = gen_box(1'b1);

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {FWD_BOX[w[31:24]], FWD_BOX[w[23:16]], FWD_BOX[w[15:8]], FWD_BOX[w[7:0]]};
  endfunction

  function automatic state_t sub_state(input state_t s, input logic inverse);
    state_t o;
    for (int i = 0; i < 16; i++) begin
      o[i] = inverse ? INV_BOX[s[i]] : FWD_BOX[s[i]];
    end
    return o;
  endfunction

  function automatic state_t shift_state(input state_t s, input logic inverse);
    state_t o;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (inverse) begin
          o[r + 4 * ((c + r) % 4)] = s[r + 4 * c];
        end else begin
          o[r + 4 * c] = s[r + 4 * ((c + r) % 4)];
        end
      end
    end
    return o;
  endfunction

  function automatic logic [7:0] mix_coef(input int j, input logic inverse);
    logic [7:0] v;
    case (j)
      0:       v = inverse ? 8'd14 : 8'd2;
      1:       v = inverse ? 8'd11 : 8'd3;
      2:       v = inverse ? 8'd13 : 8'd1;
      default: v = inverse ? 8'd9  : 8'd1;
    endcase
    return v;
  endfunction

  function automatic state_t mix_state(input state_t s, input logic inverse);
    state_t     o;
    logic [7:0] v;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int k = 0; k < 4; k++) begin
          v = v ^ gmul(mix_coef((k - r + 4) % 4, inverse), s[4 * c + k]);
        end
        o[4 * c + r] = v;
      end
    end
    return o;
  endfunction

endpackage

// ----- src/aes256_keyexp.sv -----
module aes256_keyexp (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      cfg_we,
  input  logic [aes256_pkg::CFG_IDX_W-1:0]          cfg_idx,
  input  logic [63:0]                               cfg_data,
  output logic                                      key_ready,
  output logic [aes256_pkg::ROUNDS:0][127:0]        round_keys
);
  import aes256_pkg::*;

  logic [63:0]         key_r [KEY_REGS];
  logic [31:0]         rk_r  [RK_WORDS];
  logic [RK_IDX_W-1:0] cnt_r;
  logic                busy_r;
  logic [7:0]          rcon_r;
  logic [31:0]         word_nxt;
  logic [31:0]         tmp;
  logic [63:0]         kreg;

  always_comb begin
    kreg = key_r[cnt_r[2:1]];
    tmp  = rk_r[RK_WORDS-1];
    if (cnt_r[2:0] == 3'd0) begin
      tmp = sub_word({tmp[23:0], tmp[31:24]}) ^ {rcon_r, 24'h000000};
    end else if (cnt_r[2:0] == 3'd4) begin
      tmp = sub_word(tmp);
    end
    if (cnt_r < RK_IDX_W'(KEY_WORDS)) begin
      word_nxt = cnt_r[0] ? kreg[31:0] : kreg[63:32];
    end else begin
      word_nxt = rk_r[RK_WORDS-KEY_WORDS] ^ tmp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_REGS; i++) begin
        key_r[i] <= '0;
      end
      busy_r <= 1'b1;
      cnt_r  <= '0;
      rcon_r <= 8'h01;
    end else if (cfg_we) begin
      key_r[cfg_idx] <= cfg_data;
      busy_r <= 1'b1;
      cnt_r  <= '0;
      rcon_r <= 8'h01;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == RK_IDX_W'(RK_WORDS - 1)) begin
        busy_r <= 1'b0;
      end
      if (cnt_r >= RK_IDX_W'(KEY_WORDS) && cnt_r[2:0] == 3'd0) begin
        rcon_r <= xtime(rcon_r);
      end
    end
  end

  // The key words move through a shift line; after a full pass word j sits at place j.
  always_ff @(posedge clk) begin
    if (busy_r && !cfg_we) begin
      for (int i = 0; i < RK_WORDS - 1; i++) begin
        rk_r[i] <= rk_r[i+1];
      end
      rk_r[RK_WORDS-1] <= word_nxt;
    end
  end

  always_comb begin
    for (int r = 0; r <= ROUNDS; r++) begin
      round_keys[r] = {rk_r[4*r], rk_r[4*r+1], rk_r[4*r+2], rk_r[4*r+3]};
    end
  end

  assign key_ready = !busy_r;

endmodule

// ----- src/aes256_round.sv -----
module aes256_round #(
  parameter bit LAST = 1'b0
) (
  input  aes256_pkg::state_t state_i,
  input  logic               dec_i,
  input  aes256_pkg::rkey_t  key_enc,
  input  aes256_pkg::rkey_t  key_dec,
  output aes256_pkg::state_t state_o
);
  import aes256_pkg::*;

  state_t enc_s;
  state_t dec_s;

  always_comb begin
    enc_s = shift_state(sub_state(state_i, 1'b0), 1'b0);
    if (!LAST) begin
      enc_s = mix_state(enc_s, 1'b0);
    end
    enc_s = enc_s ^ state_t'(key_enc);
    dec_s = sub_state(shift_state(state_i, 1'b1), 1'b1) ^ state_t'(key_dec);
    if (!LAST) begin
      dec_s = mix_state(dec_s, 1'b1);
    end
    state_o = dec_i ? dec_s : enc_s;
  end

endmodule

// ----- src/aes256_block_cipher.sv -----
// AES-256 block cipher, ECB, one 128-bit word per cycle unless stalled.
// Input channel: in_valid/in_stall carry an action bit (0 encrypt, 1 decrypt)
// and the block as two 64-bit halves. Output channel: out_valid/out_stall
// carry the result block. A word is taken on a clock edge with valid high and
// stall low.
// The key is written through cfg_we/cfg_idx/cfg_data, one 64-bit register at a
// time. Reset loads the all-zero key. After reset and after each key write the
// key schedule runs, one round-key word a cycle, with in_stall held high.
// The datapath is a 15-stage pipeline: one stage for the first key addition
// and one per round. A new word can enter every cycle while in_stall is low.
// When the receiver stalls, a full pipeline holds its contents and raises
// in_stall; empty stages still fill, so nothing is dropped or repeated.
module aes256_block_cipher (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  aes256_pkg::in_word_t              in_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output aes256_pkg::out_word_t             out_word,
  input  logic                              cfg_we,
  input  logic [aes256_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [63:0]                       cfg_data
);
  import aes256_pkg::*;

  logic                   key_ready;
  logic [ROUNDS:0][127:0] round_keys;
  logic [ROUNDS:0]        v_r;
  logic [ROUNDS-1:0]      dec_r;
  logic [ROUNDS:0]        adv;
  state_t                 st_r      [ROUNDS+1];
  state_t                 stage_nxt [ROUNDS+1];

  aes256_keyexp u_keyexp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .key_ready  (key_ready),
    .round_keys (round_keys)
  );

  always_comb begin
    adv[ROUNDS] = !v_r[ROUNDS] || !out_stall;
    for (int k = ROUNDS - 1; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_stall = !key_ready || !adv[0];

  assign stage_nxt[0] = state_t'({in_word.block_high, in_word.block_low}) ^
                        state_t'(in_word.action ? round_keys[ROUNDS] : round_keys[0]);

  for (genvar k = 1; k <= ROUNDS; k++) begin : g_round
    aes256_round #(.LAST(k == ROUNDS)) u_round (
      .state_i (st_r[k-1]),
      .dec_i   (dec_r[k-1]),
      .key_enc (round_keys[k]),
      .key_dec (round_keys[ROUNDS-k]),
      .state_o (stage_nxt[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid && key_ready;
      end
      for (int k = 1; k <= ROUNDS; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      st_r[0]  <= stage_nxt[0];
      dec_r[0] <= in_word.action;
    end
    for (int k = 1; k <= ROUNDS; k++) begin
      if (adv[k]) begin
        st_r[k] <= stage_nxt[k];
      end
    end
    for (int k = 1; k < ROUNDS; k++) begin
      if (adv[k]) begin
        dec_r[k] <= dec_r[k-1];
      end
    end
  end

  assign out_valid = v_r[ROUNDS];
  assign out_word  = out_word_t'(st_r[ROUNDS]);

endmodule

// ----- src/aes256_chk.sv -----
`include "assert_macros.svh"

module aes256_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input aes256_pkg::out_word_t out_word,
  input logic                  cfg_we
);

  `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))
  `CHK_IMPL(a_rst_stall, !$past(rst_n), in_stall)
  `CHK_IMPL(a_rst_empty, !$past(rst_n), !out_valid)
  `CHK_NEXT(a_cfg_stall, cfg_we, in_stall)

endmodule

bind aes256_block_cipher aes256_chk u_chk (.*);
